// File: rtl/accel_tilt_pitch_roll_top_assert.svh
// assertion macros for the tilt pitch/roll block
`ifndef ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ATPR_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tilt check failed");
`define ATPR_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tilt sequence check failed");
`else
`define ATPR_ASSERT_ALWAYS(lbl, expr)
`define ATPR_ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

// File: rtl/atpr_pkg.sv
// shared constants, tables and types for the tilt pitch/roll pipeline
`default_nettype none
package atpr_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ROOT_FRAC = 16;
	localparam int ANG_STEPS = 31;
	localparam int ANG_W = 33;
	localparam int DEG_W = 8;
	localparam logic [9:0] DEG_NUM = 10'd573;
	localparam int ANG_FRAC = 30;
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;
	localparam logic signed [DEG_W-1:0] RIGHT_ANGLE = 8'sd90;

	// atan(2^-i) in radians, q2.30
	localparam logic [31:0] ATAN_TAB [0:ANG_STEPS-1] = '{
		32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA7, 32'h03FEAB77,
		32'h01FFD55C, 32'h00FFFAAB, 32'h007FFF55, 32'h003FFFEB, 32'h001FFFFD,
		32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000, 32'h00010000,
		32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
		32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080, 32'h00000040,
		32'h00000020, 32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001
	};

	typedef struct packed {
		logic vld;
		logic flag;
	} tag_t;
endpackage
`default_nettype wire

// File: rtl/atpr_sqrt.sv
// pipelined digit-by-digit square root, one root bit per stage
`default_nettype none
module atpr_sqrt #(
	parameter int SAMPLE_BITS = atpr_pkg::SAMPLE_BITS_DEF,
	parameter int SIDE_W = 1
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         en,
	input  wire logic                                         in_vld,
	input  wire logic [2*SAMPLE_BITS-1:0]                     rad,
	input  wire logic [SIDE_W-1:0]                            side_in,
	output logic                                              out_vld,
	output logic [SAMPLE_BITS+atpr_pkg::ROOT_FRAC-1:0]        root,
	output logic [SIDE_W-1:0]                                 side_out
);
	import atpr_pkg::*;
	localparam int RB = SAMPLE_BITS + ROOT_FRAC;
	localparam int RW = 2 * RB;
	localparam int MW = RB + 3;

	logic          vld_s  [1:RB];
	logic [RW-1:0] rad_s  [1:RB];
	logic [MW-1:0] rem_s  [1:RB];
	logic [RB-1:0] root_s [1:RB];
	logic [SIDE_W-1:0] side_s [1:RB];

	for (genvar j = 0; j < RB; j++) begin : g_stage
		logic          v_in;
		logic [RW-1:0] r_in;
		logic [MW-1:0] m_in;
		logic [RB-1:0] q_in;
		logic [SIDE_W-1:0] d_in;
		logic [MW-1:0] cand;
		logic [MW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = {rad, {(2*ROOT_FRAC){1'b0}}};
			assign m_in = '0;
			assign q_in = '0;
			assign d_in = side_in;
		end else begin : g_next
			assign v_in = vld_s[j];
			assign r_in = rad_s[j];
			assign m_in = rem_s[j];
			assign q_in = root_s[j];
			assign d_in = side_s[j];
		end

		assign cand  = {m_in[MW-3:0], r_in[RW-1 -: 2]};
		assign trial = {1'b0, q_in, 2'b01};
		assign ge    = (cand >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1]  <= r_in << 2;
				rem_s[j+1]  <= ge ? (cand - trial) : cand;
				root_s[j+1] <= {q_in[RB-2:0], ge};
				side_s[j+1] <= d_in;
			end
		end
	end

	assign out_vld  = vld_s[RB];
	assign root     = root_s[RB];
	assign side_out = side_s[RB];
endmodule
`default_nettype wire

// File: rtl/atpr_cordic.sv
// pipelined vectoring cordic, one micro-rotation per stage, angle in q2.30
`default_nettype none
module atpr_cordic #(
	parameter int SAMPLE_BITS = atpr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          en,
	input  wire atpr_pkg::tag_t                                tag_in,
	input  wire logic [SAMPLE_BITS+atpr_pkg::ROOT_FRAC-1:0]    den,
	input  wire logic [SAMPLE_BITS-1:0]                        num,
	output atpr_pkg::tag_t                                     tag_out,
	output logic signed [atpr_pkg::ANG_W-1:0]                  ang
);
	import atpr_pkg::*;
	localparam int RB = SAMPLE_BITS + ROOT_FRAC;
	localparam int XW = SAMPLE_BITS + 19;

	logic                 vld_s  [1:ANG_STEPS];
	logic                 flag_s [1:ANG_STEPS];
	logic signed [XW-1:0] x_s   [1:ANG_STEPS];
	logic signed [XW-1:0] y_s   [1:ANG_STEPS];
	logic signed [ANG_W-1:0] z_s [1:ANG_STEPS];

	for (genvar i = 0; i < ANG_STEPS; i++) begin : g_stage
		logic                    v_in;
		logic                    f_in;
		logic signed [XW-1:0]    x_in;
		logic signed [XW-1:0]    y_in;
		logic signed [ANG_W-1:0] z_in;
		logic signed [XW-1:0]    dx;
		logic signed [XW-1:0]    dy;
		logic signed [ANG_W-1:0] da;

		if (i == 0) begin : g_first
			assign v_in = tag_in.vld;
			assign f_in = tag_in.flag;
			assign x_in = $signed({{(XW-RB){1'b0}}, den});
			assign y_in = $signed({{(XW-SAMPLE_BITS-ROOT_FRAC){num[SAMPLE_BITS-1]}},
				num, {ROOT_FRAC{1'b0}}});
			assign z_in = '0;
		end else begin : g_next
			assign v_in = vld_s[i];
			assign f_in = flag_s[i];
			assign x_in = x_s[i];
			assign y_in = y_s[i];
			assign z_in = z_s[i];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign da = $signed({1'b0, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flag_s[i+1] <= f_in;
				// y nonnegative rotates clockwise
				if (!y_in[XW-1]) begin
					x_s[i+1] <= x_in + dx;
					y_s[i+1] <= y_in - dy;
					z_s[i+1] <= z_in + da;
				end else begin
					x_s[i+1] <= x_in - dx;
					y_s[i+1] <= y_in + dy;
					z_s[i+1] <= z_in - da;
				end
			end
		end
	end

	assign tag_out = '{vld: vld_s[ANG_STEPS], flag: flag_s[ANG_STEPS]};
	assign ang     = z_s[ANG_STEPS];
endmodule
`default_nettype wire

// File: rtl/atpr_deg.sv
// radians to whole degrees, truncated toward zero, with saturation and override
`default_nettype none
module atpr_deg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire atpr_pkg::tag_t                       tag_in,
	input  wire logic signed [atpr_pkg::ANG_W-1:0]    ang,
	output logic                                      out_vld,
	output logic signed [atpr_pkg::DEG_W-1:0]         deg
);
	import atpr_pkg::*;
	localparam int MAGW = ANG_W - 1;
	localparam int P1W = MAGW + 10;
	localparam int TW = P1W - ANG_FRAC;
	localparam int P2W = TW + 16;
	localparam int QW = P2W - DIV10_SHIFT;

	logic [ANG_W-1:0] mag_full;
	logic           vld_s1, vld_s2;
	logic           flag_s1, flag_s2;
	logic           neg_s1, neg_s2;
	logic [P1W-1:0] prod_s1;
	logic [P2W-1:0] prod_s2;
	logic [QW-1:0]  q;
	logic [DEG_W-1:0] q_sat;
	logic           vld_s3;
	logic signed [DEG_W-1:0] deg_s3;

	assign mag_full = ang[ANG_W-1] ? (~ang + 1'b1) : ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tag_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// divide by ten as multiply by reciprocal, exact for the range of t
	assign q     = prod_s2[P2W-1:DIV10_SHIFT];
	assign q_sat = (q > QW'(RIGHT_ANGLE)) ? RIGHT_ANGLE : q[DEG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s1 <= tag_in.flag;
			neg_s1  <= ang[ANG_W-1];
			prod_s1 <= mag_full[MAGW-1:0] * DEG_NUM;
			flag_s2 <= flag_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= prod_s1[P1W-1:ANG_FRAC] * DIV10_MUL;
			if (flag_s2) begin
				deg_s3 <= RIGHT_ANGLE;
			end else if (neg_s2) begin
				deg_s3 <= -$signed(q_sat);
			end else begin
				deg_s3 <= $signed(q_sat);
			end
		end
	end

	assign out_vld = vld_s3;
	assign deg     = deg_s3;
endmodule
`default_nettype wire

// File: rtl/accel_tilt_pitch_roll_top.sv
// Tilt from one raw three-axis accelerometer sample: pitch and roll in degrees.
// Input channel: in_valid/in_ready carry accel_x, accel_y, accel_z.
// Output channel: out_valid/out_ready carry pitch_deg and roll_deg, each a
// signed whole-degree angle in -90..90, truncated toward zero.
// Every sample yields exactly one result.
// The pipeline holds registered squares, then registered sums, SAMPLE_BITS + 16
// stages of square root (one root bit each), 31 cordic stages and three stages
// of degree conversion.
// Throughput: one sample per cycle while the receiver does not stall; pitch and roll run in parallel lanes.
// The whole pipeline advances together when the result register is empty or
// being taken; a stalled receiver freezes every stage, so in_ready drops and
// nothing is lost or repeated.
// Reset clears all valid bits; the block holds no state between samples.
`default_nettype none
`include "accel_tilt_pitch_roll_top_assert.svh"
module accel_tilt_pitch_roll_top #(
	parameter int SAMPLE_BITS = atpr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]        accel_x,
	input  wire logic signed [SAMPLE_BITS-1:0]        accel_y,
	input  wire logic signed [SAMPLE_BITS-1:0]        accel_z,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [atpr_pkg::DEG_W-1:0]         pitch_deg,
	output logic signed [atpr_pkg::DEG_W-1:0]         roll_deg
);
	import atpr_pkg::*;
	localparam int B = SAMPLE_BITS;
	localparam int RB = B + ROOT_FRAC;

	logic en;
	logic vld_s1, vld_s2;
	logic [2*B-1:0] yy_s1, zz_s1;
	logic [B-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [2*B-1:0] sum_p_s2, sum_r_s2;
	logic flag_p_s2, flag_r_s2;
	logic signed [2*B-1:0] yy_full, zz_full;

	logic p_sq_vld, r_sq_vld;
	logic [RB-1:0] p_root, r_root;
	logic [B:0] p_side, r_side;
	tag_t p_tag, r_tag, p_ctag, r_ctag;
	logic signed [ANG_W-1:0] p_ang, r_ang;
	logic roll_vld;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	assign yy_full = accel_y * accel_y;
	assign zz_full = accel_z * accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yy_s1     <= yy_full;
			zz_s1     <= zz_full;
			x_s1      <= accel_x;
			y_s1      <= accel_y;
			sum_p_s2  <= yy_s1 + zz_s1;
			sum_r_s2  <= zz_s1 << 1;
			flag_p_s2 <= ((yy_s1 | zz_s1) == '0);
			flag_r_s2 <= (zz_s1 == '0);
			x_s2      <= x_s1;
			y_s2      <= y_s1;
		end
	end

	atpr_sqrt #(.SAMPLE_BITS(SAMPLE_BITS), .SIDE_W(B + 1)) u_sqrt_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(vld_s2), .rad(sum_p_s2), .side_in({flag_p_s2, x_s2}),
		.out_vld(p_sq_vld), .root(p_root), .side_out(p_side)
	);

	atpr_sqrt #(.SAMPLE_BITS(SAMPLE_BITS), .SIDE_W(B + 1)) u_sqrt_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(vld_s2), .rad(sum_r_s2), .side_in({flag_r_s2, y_s2}),
		.out_vld(r_sq_vld), .root(r_root), .side_out(r_side)
	);

	assign p_tag = '{vld: p_sq_vld, flag: p_side[B]};
	assign r_tag = '{vld: r_sq_vld, flag: r_side[B]};

	atpr_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.tag_in(p_tag), .den(p_root), .num(p_side[B-1:0]),
		.tag_out(p_ctag), .ang(p_ang)
	);

	atpr_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.tag_in(r_tag), .den(r_root), .num(r_side[B-1:0]),
		.tag_out(r_ctag), .ang(r_ang)
	);

	atpr_deg u_deg_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.tag_in(p_ctag), .ang(p_ang),
		.out_vld(out_valid), .deg(pitch_deg)
	);

	atpr_deg u_deg_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.tag_in(r_ctag), .ang(r_ang),
		.out_vld(roll_vld), .deg(roll_deg)
	);

	// both lanes advance together, so their valid bits must agree
	`ATPR_ASSERT_ALWAYS(a_lanes_aligned, roll_vld == out_valid)
	`ATPR_ASSERT_ALWAYS(a_pitch_range, !out_valid || (pitch_deg <= RIGHT_ANGLE && pitch_deg >= -RIGHT_ANGLE))
	`ATPR_ASSERT_ALWAYS(a_roll_range, !out_valid || (roll_deg <= RIGHT_ANGLE && roll_deg >= -RIGHT_ANGLE))
	// a frozen pipeline keeps its result
	`ATPR_ASSERT_IMPLY(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pitch_deg) && $stable(roll_deg))
endmodule
`default_nettype wire
